// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SIT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sit assertion failed");

// Next-cycle implication.
`define SIT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sit assertion failed");

`endif

// ===== design/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Types, sizes and operation codes of the sorted interval insert table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RIDX_W      = 8;
  localparam int CW          = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int POS_W       = 9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [31:0]       start_pos;
    logic [31:0]       end_pos;
    logic              trimmed;
    logic [15:0]       tag;
    logic [RIDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] insert_position;
    logic [POS_W-1:0] occupancy;
    logic             overflow;
    logic             read_valid;
    logic [31:0]      read_start;
    logic [31:0]      read_end;
    logic             read_trimmed;
    logic [15:0]      read_tag;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic        trimmed;
    logic [15:0] tag;
  } entry_t;

  // Per-beat control from the sequencer to every cell.
  typedef struct packed {
    logic cap;     // beat accepted: capture compare flags
    logic ins_ok;  // accepted beat is an insert with room left
    logic commit;  // busy cycle of an insert: shift and load
  } cell_ctl_t;

endpackage

// ===== design/sit_cell.sv =====
// ----------------------------------------------------------------------------
// sit_cell
// One table slot: compares its entry with the incoming key, decides whether
// it shifts right, and takes the new entry or its left neighbor's entry.
// ----------------------------------------------------------------------------
module sit_cell import sit_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [CNT_W-1:0]  count,
  input  entry_t            key,
  input  logic [RIDX_W-1:0] rd_idx,
  input  entry_t            new_ent,
  input  logic              right_le,
  input  logic              left_move,
  input  logic              left_move_r,
  input  entry_t            left_ent,
  output logic              le,
  output logic              move,
  output logic              move_r,
  output logic              load_r,
  output entry_t            ent,
  output entry_t            rd_data
);

  entry_t ent_r;
  logic   sel_r;
  logic   valid;
  logic   at_count;
  logic   gt;
  logic   tie;

  assign valid    = CNT_W'(cell_idx) < count;
  assign at_count = CNT_W'(cell_idx) == count;
  assign gt       = key.start_pos < ent_r.start_pos;
  assign tie      = (key.start_pos == ent_r.start_pos) &&
                    ((key.trimmed && !ent_r.trimmed) ||
                     ((key.trimmed == ent_r.trimmed) && (key.end_pos < ent_r.end_pos)));
  assign le       = valid && !gt;
  // Only the last entry with start not above the key settles a tie.
  assign move     = valid && (gt || (tie && !right_le));

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      move_r <= ctl.ins_ok && move;
      load_r <= ctl.ins_ok && !left_move && (move || at_count);
      sel_r  <= CW'(cell_idx) == CW'(rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (load_r) begin
        ent_r <= new_ent;
      end else if (left_move_r) begin
        ent_r <= left_ent;
      end
    end
  end

  assign ent     = ent_r;
  assign rd_data = sel_r ? ent_r : '0;

endmodule

// ===== design/sorted_interval_insert_table.sv =====
// ----------------------------------------------------------------------------
// sorted_interval_insert_table
// Interval table kept in start order by a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken on a rising edge where
//   busy is low. func selects insert, read at read_index, clear, or no-op.
//   Every accepted beat yields exactly one result: out_strobe is registered
//   from busy and rises with the registered result, taken while it is high.
//   The receiver cannot stall; results must be captured when strobed.
// Timing:
//   In the accept cycle every cell compares its entry with the key and
//   registers its shift/load decision; in the next cycle (busy high) the
//   cells shift right one slot and the new entry is loaded, while the read
//   mux and the position encoder are registered into the output. A new
//   beat can be taken while the result is shown.
// Reset:
//   Synchronous, active low. The table comes up empty; entry contents are
//   not cleared and are only read below the occupancy count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_interval_insert_table import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [1:0]       op_r;
  logic             ins_r;
  logic             ovf_r;
  logic             rd_ok_r;
  entry_t           new_r;
  logic             out_strobe_r;
  out_item_t        out_r;
  out_item_t        out_nxt;

  logic             accept;
  logic             full;
  cell_ctl_t        ctl;
  entry_t           key;

  logic   [TABLE_DEPTH-1:0] le_vec;
  logic   [TABLE_DEPTH-1:0] move_vec;
  logic   [TABLE_DEPTH-1:0] move_r_vec;
  logic   [TABLE_DEPTH-1:0] load_vec;
  entry_t                   ent_vec [TABLE_DEPTH];
  entry_t                   rd_vec  [TABLE_DEPTH];

  entry_t           rd_or;
  logic [IDX_W-1:0] pos;

  assign accept = start && !busy_r;
  assign full   = count_r == CNT_W'(TABLE_DEPTH);
  assign busy   = busy_r;

  assign key.start_pos = in_item.start_pos;
  assign key.end_pos   = in_item.end_pos;
  assign key.trimmed   = in_item.trimmed;
  assign key.tag       = in_item.tag;

  assign ctl.cap    = accept;
  assign ctl.ins_ok = accept && (in_item.func == OP_INSERT) && !full;
  assign ctl.commit = busy_r && ins_r;

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    logic   right_le;
    logic   left_move;
    logic   left_move_r;
    entry_t left_ent;

    if (gi == TABLE_DEPTH - 1) begin : g_last
      assign right_le = 1'b0;
    end else begin : g_mid
      assign right_le = le_vec[gi+1];
    end

    if (gi == 0) begin : g_first
      assign left_move   = 1'b0;
      assign left_move_r = 1'b0;
      assign left_ent    = '0;
    end else begin : g_rest
      assign left_move   = move_vec[gi-1];
      assign left_move_r = move_r_vec[gi-1];
      assign left_ent    = ent_vec[gi-1];
    end

    sit_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_idx    (IDX_W'(gi)),
      .count       (count_r),
      .key         (key),
      .rd_idx      (in_item.read_index),
      .new_ent     (new_r),
      .right_le    (right_le),
      .left_move   (left_move),
      .left_move_r (left_move_r),
      .left_ent    (left_ent),
      .le          (le_vec[gi]),
      .move        (move_vec[gi]),
      .move_r      (move_r_vec[gi]),
      .load_r      (load_vec[gi]),
      .ent         (ent_vec[gi]),
      .rd_data     (rd_vec[gi])
    );
  end

  // One-hot select: OR the gated cell outputs together.
  always_comb begin
    rd_or = '0;
    pos   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rd_or = rd_or | rd_vec[i];
      pos   = pos | (load_vec[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    unique case (op_r)
      OP_INSERT: count_nxt = ins_r ? count_r + CNT_W'(1) : count_r;
      OP_CLEAR:  count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  always_comb begin
    out_nxt                 = '0;
    out_nxt.occupancy       = POS_W'(count_nxt);
    out_nxt.insert_position = ins_r ? POS_W'(pos) : '0;
    out_nxt.overflow        = ovf_r;
    out_nxt.read_valid      = rd_ok_r;
    if (rd_ok_r) begin
      out_nxt.read_start   = rd_or.start_pos;
      out_nxt.read_end     = rd_or.end_pos;
      out_nxt.read_trimmed = rd_or.trimmed;
      out_nxt.read_tag     = rd_or.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= accept;
      out_strobe_r <= busy_r;
      if (busy_r) begin
        count_r <= count_nxt;
      end
    end
  end

  // Hold the beat for the commit cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r            <= in_item.func;
      ins_r           <= ctl.ins_ok;
      ovf_r           <= (in_item.func == OP_INSERT) && full;
      rd_ok_r         <= (in_item.func == OP_READ) &&
                         (CW'(in_item.read_index) < CW'(count_r));
      new_r           <= key;
    end
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  `SIT_ASSERT_NXT(a_busy_after_accept, accept, busy_r)
  `SIT_ASSERT_NXT(a_strobe_follows_busy, busy_r, out_strobe_r)
  `SIT_ASSERT_NXT(a_no_stray_strobe, !busy_r, !out_strobe_r)
  `SIT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_DEPTH))
  `SIT_ASSERT_IMP(a_single_load, busy_r && ins_r, $onehot(load_vec))
  `SIT_ASSERT_IMP(a_ovf_when_full, out_strobe_r && out_r.overflow,
                  out_r.occupancy == POS_W'(TABLE_DEPTH))

endmodule

// ===== bench/sorted_interval_insert_table_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_interval_insert_table_tb
// Self-checking bench for the start-ordered interval table. Beats are driven
// through the start/busy handshake. Each accepted beat updates a private copy
// of the table, which predicts the one result that the beat produces. Strobed
// results are checked field by field against the oldest prediction. The run
// covers directed tie cases, a full-table fill with overflow, and random
// insert/read/clear traffic under several sender idle rates.
// ----------------------------------------------------------------------------
module sorted_interval_insert_table_tb;
  import sit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_BEATS = 290;

  class interval_table_scoreboard;
    entry_t      rows[TABLE_DEPTH];
    int unsigned row_count = 0;
    out_item_t   pending_results[$];
    int unsigned errors = 0;
    int unsigned n_beats = 0;
    int unsigned n_inserts = 0;
    int unsigned n_overflows = 0;
    int unsigned n_read_hits = 0;
    int unsigned n_clears = 0;
    int unsigned n_checked = 0;

    // Apply one beat to the table copy and return the result it yields.
    function out_item_t apply_beat(in_item_t it);
      out_item_t   r;
      int unsigned slot;
      int unsigned anchor;
      int unsigned i;
      r = '0;
      case (it.func)
        OP_INSERT: begin
          n_inserts++;
          if (row_count >= TABLE_DEPTH) begin
            r.overflow = 1'b1;
            n_overflows++;
          end else begin
            slot = row_count;
            while (slot > 0 && it.start_pos < rows[slot - 1].start_pos) slot--;
            // Only the last entry with start not above ours settles a tie.
            if (slot > 0) begin
              anchor = slot - 1;
              if (it.start_pos == rows[anchor].start_pos &&
                  ((it.trimmed && !rows[anchor].trimmed) ||
                   (it.trimmed == rows[anchor].trimmed &&
                    it.end_pos < rows[anchor].end_pos)))
                slot = anchor;
            end
            for (i = row_count; i > slot; i--) rows[i] = rows[i - 1];
            rows[slot].start_pos = it.start_pos;
            rows[slot].end_pos   = it.end_pos;
            rows[slot].trimmed   = it.trimmed;
            rows[slot].tag       = it.tag;
            row_count++;
            r.insert_position = slot[POS_W-1:0];
          end
        end
        OP_READ: begin
          if (it.read_index < row_count) begin
            n_read_hits++;
            r.read_valid   = 1'b1;
            r.read_start   = rows[it.read_index].start_pos;
            r.read_end     = rows[it.read_index].end_pos;
            r.read_trimmed = rows[it.read_index].trimmed;
            r.read_tag     = rows[it.read_index].tag;
          end
        end
        OP_CLEAR: begin
          n_clears++;
          row_count = 0;
        end
        default: ;
      endcase
      r.occupancy = row_count[POS_W-1:0];
      return r;
    endfunction

    function void note_beat(in_item_t it);
      out_item_t exp_r;
      n_beats++;
      exp_r = apply_beat(it);
      pending_results = {pending_results, exp_r};
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result strobed with no beat outstanding");
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      n_checked++;
      field_check("insert_position", exp_r.insert_position, got.insert_position);
      field_check("occupancy", exp_r.occupancy, got.occupancy);
      field_check("overflow", exp_r.overflow, got.overflow);
      field_check("read_valid", exp_r.read_valid, got.read_valid);
      field_check("read_start", exp_r.read_start, got.read_start);
      field_check("read_end", exp_r.read_end, got.read_end);
      field_check("read_trimmed", exp_r.read_trimmed, got.read_trimmed);
      field_check("read_tag", exp_r.read_tag, got.read_tag);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  interval_table_scoreboard sb;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  sorted_interval_insert_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_interval_insert_table_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // Present one beat from a falling edge and hold it until taken.
  task automatic send_beat(input in_item_t it);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_beat(it);
    @(negedge clk);
  endtask

  task automatic send_insert(input logic [31:0] s, input logic [31:0] e,
                             input logic t, input logic [15:0] g);
    in_item_t it;
    it = '0;
    it.func      = OP_INSERT;
    it.start_pos = s;
    it.end_pos   = e;
    it.trimmed   = t;
    it.tag       = g;
    send_beat(it);
  endtask

  task automatic send_op(input logic [1:0] f, input logic [7:0] idx);
    in_item_t it;
    it = '0;
    it.func       = f;
    it.read_index = idx;
    send_beat(it);
  endtask

  function automatic in_item_t random_beat(int unsigned occ);
    in_item_t    it;
    int unsigned pick;
    it = '0;
    it.start_pos  = $urandom;
    it.end_pos    = $urandom;
    it.trimmed    = 1'($urandom_range(1));
    it.tag        = 16'($urandom_range(16'hFFFF));
    it.read_index = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 55) it.func = OP_INSERT;
    else if (pick < 88) it.func = OP_READ;
    else if (pick < 94) it.func = OP_NOP;
    else it.func = OP_CLEAR;
    // Crowd starts and ends into small ranges so ties come up often.
    pick = $urandom_range(9);
    if (pick < 6) it.start_pos = $urandom_range(20);
    else if (pick == 6) it.start_pos = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    if ($urandom_range(1)) it.end_pos = $urandom_range(8);
    if (occ > 0 && $urandom_range(3) != 0) it.read_index = 8'($urandom_range(occ - 1));
    return it;
  endfunction

  initial begin
    int unsigned i;
    int unsigned phase;
    sb = new;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty insert, tie rules, extremes, reads, no-op, clear.
    send_insert(32'd100, 32'd50, 1'b0, 16'h0001);
    send_insert(32'd100, 32'd40, 1'b1, 16'h0002);
    send_insert(32'd100, 32'd60, 1'b0, 16'h0003);
    send_insert(32'd100, 32'd10, 1'b0, 16'h0004);
    send_insert(32'd100, 32'd5, 1'b1, 16'h0005);
    send_insert(32'd100, 32'd60, 1'b0, 16'h0006);
    send_insert(32'd200, 32'd9, 1'b1, 16'h0007);
    send_insert(32'd200, 32'd1, 1'b0, 16'h0008);
    send_insert(32'd200, 32'd1, 1'b1, 16'h0009);
    send_insert(32'h0, 32'h0, 1'b0, 16'h0000);
    send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_insert(32'hFFFF_FFFF, 32'h0, 1'b1, 16'hA5A5);
    for (i = 0; i < 12; i++) send_op(OP_READ, i[7:0]);
    send_op(OP_READ, 8'hFF);
    send_op(OP_NOP, 8'h00);
    send_op(OP_CLEAR, 8'h00);
    send_op(OP_READ, 8'h00);
    send_insert(32'd7, 32'd7, 1'b0, 16'h1234);

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 46 : 10;
      if (phase == 1) begin
        // Fill the table past capacity, then read both ends and the middle.
        send_op(OP_CLEAR, 8'h00);
        for (i = 0; i < TABLE_DEPTH + 3; i++)
          send_insert($urandom_range(1000), $urandom_range(8), 1'($urandom_range(1)),
                      16'($urandom_range(16'hFFFF)));
        send_op(OP_READ, 8'd0);
        send_op(OP_READ, 8'd128);
        send_op(OP_READ, 8'hFF);
        send_op(OP_CLEAR, 8'h00);
      end
      for (i = 0; i < PHASE_BEATS; i++) send_beat(random_beat(sb.row_count));
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end

    $display("Ran %0d beats, %0d results checked: %0d inserts (%0d dropped on full table),",
             sb.n_beats, sb.n_checked, sb.n_inserts, sb.n_overflows);
    $display("%0d reads returning data, %0d clears, sender idle rates 0/46/10 percent.",
             sb.n_read_hits, sb.n_clears);
    if (sb.errors == 0) begin
      $display("sorted_interval_insert_table_tb OK");
    end else begin
      $display("sorted_interval_insert_table_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/sit_pkg.sv
design/sit_cell.sv
design/sorted_interval_insert_table.sv
bench/sorted_interval_insert_table_tb.sv
